// ===== rtl/xtea_block_cipher_assert.svh =====
// assertion macros for the xtea block cipher rtl
// each use sits on a line of its own inside a module that has clock and reset
`ifndef XTEA_BLOCK_CIPHER_ASSERT_SVH
`define XTEA_BLOCK_CIPHER_ASSERT_SVH

`ifndef SYNTH
// checked only outside reset
`define XTEA_ASSERT(label, prop) \
   label: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error("xtea assertion failed");
// checked at every edge, reset included
`define XTEA_ASSERT_RST(label, prop) \
   label: assert property (@(posedge clock) prop) \
      else $error("xtea reset assertion failed");
`else
`define XTEA_ASSERT(label, prop)
`define XTEA_ASSERT_RST(label, prop)
`endif

`endif

// ===== rtl/xtea_pkg.sv =====
`default_nettype none

package xtea_pkg;

   // cipher cycles per block, two feistel rounds each
   localparam int unsigned CYCLES     = 32;
   localparam int unsigned NUM_ROUNDS = 2 * CYCLES;

   localparam logic [31:0] XTEA_DELTA = 32'h9E37_79B9;

   localparam int unsigned WORD_W      = 32;
   localparam int unsigned BLOCK_W     = 2 * WORD_W;
   localparam int unsigned NUM_KEYS    = 4;
   localparam int unsigned CSR_INDEX_W = $clog2(NUM_KEYS);

   // key register indexes on the csr port
   typedef enum logic [CSR_INDEX_W-1:0] {
      KEY_WORD_0,
      KEY_WORD_1,
      KEY_WORD_2,
      KEY_WORD_3
   } csr_index_type;

   typedef logic [NUM_KEYS-1:0][WORD_W-1:0] key_set_type;

   // one block in flight
   typedef struct packed {
      logic              func;   // 0 encrypt, 1 decrypt
      logic [WORD_W-1:0] left;
      logic [WORD_W-1:0] right;
   } item_type;

   // per round constants, fixed at elaboration
   typedef struct packed {
      logic              odd;
      logic [WORD_W-1:0] sum_enc;
      logic [WORD_W-1:0] sum_dec;
   } round_const_type;

   function automatic round_const_type round_const(input int unsigned rnd);
      int unsigned     steps;
      logic [63:0]     enc_p;
      logic [63:0]     dec_p;
      round_const_type c;
      steps   = (rnd + 1) >> 1;
      enc_p   = 64'(steps) * 64'(XTEA_DELTA);
      dec_p   = 64'(CYCLES - steps) * 64'(XTEA_DELTA);
      c.odd     = rnd[0];
      c.sum_enc = enc_p[WORD_W-1:0];
      c.sum_dec = dec_p[WORD_W-1:0];
      return c;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/xtea_block_cipher.sv =====
`default_nettype none

// xtea block cipher, 64-bit block, 128-bit key, fully unrolled
//
// req channel: one beat carries req_func (0 encrypt, 1 decrypt) and
// req_block_in, left word in bits 31:0, right word in bits 63:32
// rsp channel: one beat per request, in request order, with the processed
// block on rsp_block_out, right word in bits 63:32
// csr channel: csr_index picks key word 0..3, csr_wdata is the word;
// always ready, write keys only while no block is in flight
//
// path: the req beat passes one register per feistel round (64 rounds)
// and then the output register before it shows on rsp_valid
// throughput: one block per cycle unless stalled, one-round-per-stage pipeline
// reset: keys go to zero, all stage valids, rsp_valid and the skid slot are cleared
// stall: a waiting rsp beat lets one more block land in a skid slot, then
// the whole pipeline and req_ready hold until the receiver takes a beat
module xtea_block_cipher (
   input  wire                               clock,
   input  wire                               reset,
   input  wire                               req_valid,
   output logic                              req_ready,
   input  wire                               req_func,
   input  wire [xtea_pkg::BLOCK_W-1:0]       req_block_in,
   output logic                              rsp_valid,
   input  wire                               rsp_ready,
   output logic [xtea_pkg::BLOCK_W-1:0]      rsp_block_out,
   input  wire                               csr_valid,
   output logic                              csr_ready,
   input  wire [xtea_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  wire [xtea_pkg::WORD_W-1:0]        csr_wdata
);
   import xtea_pkg::*;

   // key registers
   key_set_type key_ff;

   // stage 0 is the request itself, stage r+1 the register after round r
   logic     stage_valid [NUM_ROUNDS+1];
   item_type stage_item  [NUM_ROUNDS+1];
   logic     en;
   item_type last_item;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         key_ff <= '0;
      end else if (csr_valid) begin
         case (csr_index)
            KEY_WORD_0: key_ff[0] <= csr_wdata;
            KEY_WORD_1: key_ff[1] <= csr_wdata;
            KEY_WORD_2: key_ff[2] <= csr_wdata;
            KEY_WORD_3: key_ff[3] <= csr_wdata;
            default:    key_ff    <= key_ff;
         endcase
      end
   end

   // request beat feeds the first round directly
   assign req_ready           = en;
   assign stage_valid[0]      = req_valid;
   assign stage_item[0].func  = req_func;
   assign stage_item[0].left  = req_block_in[WORD_W-1:0];
   assign stage_item[0].right = req_block_in[BLOCK_W-1:WORD_W];

   // one feistel round per stage, round sums fixed per stage
   for (genvar r = 0; r < NUM_ROUNDS; r++) begin : g_round
      xtea_round u_round (
         .clock       (clock),
         .reset       (reset),
         .en          (en),
         .prev_valid  (stage_valid[r]),
         .prev_item   (stage_item[r]),
         .keys        (key_ff),
         .rconst      (round_const(r)),
         .stage_valid (stage_valid[r+1]),
         .stage_item  (stage_item[r+1])
      );
   end

   assign last_item = stage_item[NUM_ROUNDS];

   // output register and skid slot, drives the global stage enable
   xtea_out u_out (
      .clock         (clock),
      .reset         (reset),
      .pe_valid      (stage_valid[NUM_ROUNDS]),
      .pe_block      ({last_item.right, last_item.left}),
      .en            (en),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_block_out (rsp_block_out)
   );

endmodule

`default_nettype wire

// ===== rtl/xtea_round.sv =====
`default_nettype none

module xtea_round (
   input  wire                            clock,
   input  wire                            reset,
   input  wire                            en,
   input  wire                            prev_valid,
   input  wire xtea_pkg::item_type        prev_item,
   input  wire xtea_pkg::key_set_type     keys,
   input  wire xtea_pkg::round_const_type rconst,
   output logic                           stage_valid,
   output xtea_pkg::item_type             stage_item
);
   import xtea_pkg::*;

   logic              valid_ff;
   item_type          item_ff;
   item_type          item_in;
   logic              upd_left;
   logic [WORD_W-1:0] src;
   logic [WORD_W-1:0] dst;
   logic [WORD_W-1:0] mixed;
   logic [WORD_W-1:0] sum;
   logic [1:0]        kidx;
   logic [WORD_W-1:0] f;
   logic [WORD_W-1:0] res;

   // even encrypt and odd decrypt rounds update the left word
   always_comb begin
      upd_left = ~(rconst.odd ^ prev_item.func);
      src      = upd_left ? prev_item.right : prev_item.left;
      dst      = upd_left ? prev_item.left : prev_item.right;
      mixed    = ((src << 4) ^ (src >> 5)) + src;
      sum      = prev_item.func ? rconst.sum_dec : rconst.sum_enc;
      kidx     = upd_left ? sum[1:0] : sum[12:11];
      f        = mixed ^ (sum + keys[kidx]);
      res      = prev_item.func ? (dst - f) : (dst + f);
      item_in  = prev_item;
      if (upd_left) begin
         item_in.left = res;
      end else begin
         item_in.right = res;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= prev_valid;
      end
      if (en) begin
         item_ff <= item_in;
      end
   end

   assign stage_valid = valid_ff;
   assign stage_item  = item_ff;

endmodule

`default_nettype wire

// ===== rtl/xtea_out.sv =====
`default_nettype none

`include "xtea_block_cipher_assert.svh"

module xtea_out (
   input  wire                            clock,
   input  wire                            reset,
   input  wire                            pe_valid,
   input  wire [xtea_pkg::BLOCK_W-1:0]    pe_block,
   output logic                           en,
   output logic                           rsp_valid,
   input  wire                            rsp_ready,
   output logic [xtea_pkg::BLOCK_W-1:0]   rsp_block_out
);
   import xtea_pkg::*;

   logic               rsp_valid_ff;
   logic               rsp_valid_in;
   logic [BLOCK_W-1:0] rsp_block_ff;
   logic [BLOCK_W-1:0] rsp_block_in;
   logic               skid_valid_ff;
   logic               skid_valid_in;
   logic [BLOCK_W-1:0] skid_block_ff;
   logic [BLOCK_W-1:0] skid_block_in;
   logic               out_load;

   // pipeline moves only while the skid slot is empty
   assign en = ~skid_valid_ff;

   always_comb begin
      out_load      = ~rsp_valid_ff | rsp_ready;
      rsp_valid_in  = rsp_valid_ff;
      rsp_block_in  = rsp_block_ff;
      skid_valid_in = skid_valid_ff;
      skid_block_in = skid_block_ff;
      if (skid_valid_ff) begin
         if (out_load) begin
            rsp_valid_in  = 1'b1;
            rsp_block_in  = skid_block_ff;
            skid_valid_in = 1'b0;
         end
      end else if (out_load) begin
         rsp_valid_in = pe_valid;
         rsp_block_in = pe_block;
      end else if (pe_valid) begin
         skid_valid_in = 1'b1;
         skid_block_in = pe_block;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff  <= rsp_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      rsp_block_ff  <= rsp_block_in;
      skid_block_ff <= skid_block_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_block_out = rsp_block_ff;

   `XTEA_ASSERT_RST(a_reset_empties, reset |=> !rsp_valid_ff && !skid_valid_ff)
   `XTEA_ASSERT(a_skid_needs_out, skid_valid_ff |-> rsp_valid_ff)
   `XTEA_ASSERT(a_skid_catches, pe_valid && en && rsp_valid_ff && !rsp_ready |=> skid_valid_ff)
   `XTEA_ASSERT(a_skid_drains, skid_valid_ff && rsp_ready |=> !skid_valid_ff && rsp_valid_ff)
   `XTEA_ASSERT(a_skid_cause, $rose(skid_valid_ff) |-> $past(rsp_valid_ff && !rsp_ready))

endmodule

`default_nettype wire

// ===== bench/xtea_block_cipher_tb.sv =====
`timescale 1ns / 100ps

// keeps its own copy of the key and a queue of the blocks still due on rsp
class xtea_scoreboard;
   logic [31:0] key_words [xtea_pkg::NUM_KEYS];
   logic [63:0] blocks_due [$];
   int unsigned failures;

   function new();
      foreach (key_words[i]) key_words[i] = '0;
      failures = 0;
   endfunction

   function void set_key(xtea_pkg::csr_index_type ix, logic [31:0] word);
      key_words[ix] = word;
   endfunction

   function logic [31:0] mix_word(logic [31:0] w);
      return ((w << 4) ^ (w >> 5)) + w;
   endfunction

   function logic [63:0] xtea_cipher(bit decrypt, logic [63:0] blk);
      logic [31:0] left;
      logic [31:0] right;
      logic [31:0] sum;
      left  = blk[31:0];
      right = blk[63:32];
      if (!decrypt) begin
         sum = '0;
         repeat (xtea_pkg::CYCLES) begin
            left  += mix_word(right) ^ (sum + key_words[sum[1:0]]);
            sum   += xtea_pkg::XTEA_DELTA;
            right += mix_word(left) ^ (sum + key_words[sum[12:11]]);
         end
      end else begin
         sum = xtea_pkg::XTEA_DELTA * 32'(xtea_pkg::CYCLES);
         repeat (xtea_pkg::CYCLES) begin
            right -= mix_word(left) ^ (sum + key_words[sum[12:11]]);
            sum   -= xtea_pkg::XTEA_DELTA;
            left  -= mix_word(right) ^ (sum + key_words[sum[1:0]]);
         end
      end
      return {right, left};
   endfunction

   function void note_request(bit decrypt, logic [63:0] blk);
      blocks_due.push_back(xtea_cipher(decrypt, blk));
   endfunction

   function void check_response(logic [63:0] got);
      logic [63:0] want;
      if (blocks_due.size() == 0) begin
         $error("block_out beat with nothing due: expected none, actual %h", got);
         failures++;
      end else begin
         want = blocks_due.pop_front();
         if (got !== want) begin
            $error("block_out mismatch: expected %h, actual %h", want, got);
            failures++;
         end
      end
   endfunction

   function int unsigned pending();
      return blocks_due.size();
   endfunction
endclass

module xtea_block_cipher_tb;
   import xtea_pkg::*;

   logic                clock;
   logic                reset;
   logic                req_valid;
   logic                req_ready;
   logic                req_func;
   logic [BLOCK_W-1:0]  req_block_in;
   logic                rsp_valid;
   logic                rsp_ready;
   logic [BLOCK_W-1:0]  rsp_block_out;
   logic                csr_valid;
   logic                csr_ready;
   csr_index_type       csr_index;
   logic [WORD_W-1:0]   csr_wdata;

   xtea_scoreboard sb;

   // idling knobs, changed by the stimulus as the run goes on
   int unsigned send_idle_pct;
   int unsigned rsp_stall_pct;
   bit          quiet;

   localparam int unsigned NUM_PHASES      = 6;
   localparam int unsigned ITEMS_PER_PHASE = 280;
   localparam int unsigned CHUNK           = 64;
   // 64 round stages plus the output register, with some margin
   localparam int unsigned TAIL_CYCLES     = 80;

   xtea_block_cipher dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_func      (req_func),
      .req_block_in  (req_block_in),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_block_out (rsp_block_out),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata)
   );

   // 20 ns period
   initial clock = 1'b0;
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // hard stop well past the slowest legal run
   initial begin
      #20_000_000;
      $display("[FAIL] regression broken");
      $finish;
   end

   // rsp side: check each beat, then pick ready for the next edge
   initial begin : rsp_side
      int unsigned stall_left;
      stall_left = 0;
      rsp_ready  = 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         // values seen here are the ones sampled at this edge
         if (rsp_valid && rsp_ready) sb.check_response(rsp_block_out);
         if (stall_left > 0) begin
            rsp_ready <= 1'b0;
            stall_left--;
         end else begin
            rsp_ready <= 1'b1;
            if (!quiet && $urandom_range(99, 0) < rsp_stall_pct)
               stall_left = $urandom_range(11, 1);
         end
         @(posedge clock);
      end
   end

   // one req beat; valid is left high so back-to-back beats need no toggle
   task automatic send_block(bit decrypt, logic [63:0] blk);
      req_valid    <= 1'b1;
      req_func     <= decrypt;
      req_block_in <= blk;
      do @(posedge clock); while (!req_ready);
      sb.note_request(decrypt, blk);
   endtask

   task automatic idle_sender(int unsigned cycles);
      req_valid <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   // random gap after a beat, per the current knob
   task automatic maybe_idle();
      if (!quiet && $urandom_range(99, 0) < send_idle_pct)
         idle_sender($urandom_range(11, 1));
   endtask

   // hold off until every block in flight has come back
   task automatic drain();
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
   endtask

   // write all four key words; only called with the pipeline empty
   task automatic load_keys(logic [WORD_W-1:0] words [NUM_KEYS]);
      csr_index_type ix;
      ix = ix.first();
      repeat (NUM_KEYS) begin
         csr_valid <= 1'b1;
         csr_index <= ix;
         csr_wdata <= words[ix];
         do @(posedge clock); while (!csr_ready);
         sb.set_key(ix, words[ix]);
         ix = ix.next();
      end
      // sometimes overwrite one word, last write has to win
      if ($urandom_range(1, 0) == 1) begin
         ix = csr_index_type'($urandom_range(NUM_KEYS - 1, 0));
         words[ix] = $urandom;
         csr_index <= ix;
         csr_wdata <= words[ix];
         do @(posedge clock); while (!csr_ready);
         sb.set_key(ix, words[ix]);
      end
      csr_valid <= 1'b0;
   endtask

   function automatic logic [WORD_W-1:0] pick_key_word();
      case ($urandom_range(3, 0))
         0:       return '0;
         1:       return '1;
         default: return $urandom;
      endcase
   endfunction

   // mostly uniform blocks, some with one or both halves pinned
   function automatic logic [63:0] pick_block();
      case ($urandom_range(7, 0))
         0:       return {32'h0000_0000, 32'($urandom)};
         1:       return {32'($urandom), 32'hFFFF_FFFF};
         2:       return {32'hFFFF_FFFF, 32'h0000_0000};
         default: return {32'($urandom), 32'($urandom)};
      endcase
   endfunction

   // corner blocks, each both ways
   task automatic run_corner_blocks();
      logic [63:0] corners [6];
      corners = '{64'h0, '1, 64'h1, 64'h8000_0000_0000_0000,
                  64'hAAAA_AAAA_5555_5555, 64'h0000_0000_FFFF_FFFF};
      foreach (corners[i]) begin
         send_block(1'b0, corners[i]);
         send_block(1'b1, corners[i]);
         maybe_idle();
      end
   endtask

   initial begin : stimulus
      logic [WORD_W-1:0] words [NUM_KEYS];
      logic [63:0]       blk;
      logic [63:0]       cipher_text;
      bit                decrypt;
      sb = new();
      quiet         = 1'b0;
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_func      = 1'b0;
      req_block_in  = '0;
      csr_valid     = 1'b0;
      csr_index     = KEY_WORD_0;
      csr_wdata     = '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // corner blocks under the reset key, then under the all-ones key
      send_idle_pct = 20;
      rsp_stall_pct = 20;
      run_corner_blocks();
      drain();
      foreach (words[i]) words[i] = '1;
      load_keys(words);
      run_corner_blocks();

      for (int unsigned phase = 0; phase < NUM_PHASES; phase++) begin
         // key changes only with nothing in flight
         drain();
         foreach (words[i]) words[i] = (phase == 3) ? '0 : pick_key_word();
         load_keys(words);
         quiet = (phase == NUM_PHASES - 1);
         for (int unsigned n = 0; n < ITEMS_PER_PHASE; n++) begin
            // re-roll the idling mix now and then, zero gives clean stretches
            if (n % CHUNK == 0) begin
               send_idle_pct = ($urandom_range(2, 0) == 0) ? 0 : $urandom_range(40, 5);
               rsp_stall_pct = ($urandom_range(2, 0) == 0) ? 0 : $urandom_range(40, 5);
            end
            decrypt = $urandom_range(1, 0);
            blk     = pick_block();
            send_block(decrypt, blk);
            // round trip: feed the result back the other way
            if ($urandom_range(3, 0) == 0) begin
               cipher_text = sb.xtea_cipher(decrypt, blk);
               send_block(!decrypt, cipher_text);
               n++;
            end
            maybe_idle();
         end
      end

      drain();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (sb.failures == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end
endmodule
